[hdl/spq_pkg.sv]
// Package for the sorted priority queue: payload structs, operation and
// status codes, default depth. No dependencies.
package spq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned ValueW       = 16;
  localparam int unsigned PrioW        = 8;
  localparam int unsigned OccW         = 7;

  // Operation codes carried in the func field.
  localparam logic FuncPush = 1'b0;
  localparam logic FuncPop  = 1'b1;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  typedef struct packed {
    logic              func;
    logic [ValueW-1:0] item_value;
    logic [PrioW-1:0]  item_priority;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] head_value;
    logic [PrioW-1:0]  head_priority;
    logic [OccW-1:0]   occupancy;
  } out_t;

  // Commands from the controller to the cell array.
  typedef struct packed {
    logic do_push;   // insert the incoming entry
    logic do_pop;    // shift every entry one place towards the head
    logic load_out;  // capture the head into the output register
  } spq_cmd_t;

endpackage

[hdl/spq_ctrl.sv]
// Controller of the sorted priority queue: fill state machine, entry count,
// handshake and result status. Depends on spq_pkg.
module spq_ctrl #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output spq_pkg::status_e           status_o,
  output spq_pkg::spq_cmd_t          cmd_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_EMPTY,
    S_PARTIAL,
    S_FULL
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic            accept;
  logic            is_pop;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pop     = (func_i == FuncPop);

  always_comb begin
    cmd_o.do_push  = accept && !is_pop && (state_q != S_FULL);
    cmd_o.do_pop   = accept && is_pop && (state_q != S_EMPTY);
    cmd_o.load_out = accept;

    count_d = count_q;
    if (cmd_o.do_push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_o.do_pop) begin
      count_d = count_q - CntW'(1);
    end

    if (count_d == '0) begin
      state_d = S_EMPTY;
    end else if (count_d == CntW'(DEPTH)) begin
      state_d = S_FULL;
    end else begin
      state_d = S_PARTIAL;
    end

    status_d = status_q;
    if (accept) begin
      if (!is_pop && (state_q == S_FULL)) begin
        status_d = StOverflow;
      end else if (is_pop && (state_q == S_EMPTY)) begin
        status_d = StUnderflow;
      end else begin
        status_d = StOk;
      end
    end

    // Hold a result until taken; a new transaction replaces it.
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_EMPTY;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StOk;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

endmodule

[hdl/spq_datapath.sv]
// Cell array of the sorted priority queue: one compare-and-shift cell per
// slot, head first, plus the output head register. Depends on spq_pkg.
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  spq_pkg::spq_cmd_t            cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  logic [spq_pkg::ValueW-1:0]   item_value_i,
  input  logic [spq_pkg::PrioW-1:0]    item_priority_i,
  output logic [spq_pkg::ValueW-1:0]   head_value_o,
  output logic [spq_pkg::PrioW-1:0]    head_priority_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [ValueW-1:0] val_q [DEPTH];
  logic [PrioW-1:0]  pri_q [DEPTH];
  logic [ValueW-1:0] val_d [DEPTH];
  logic [PrioW-1:0]  pri_d [DEPTH];
  logic [ValueW-1:0] head_value_q;
  logic [PrioW-1:0]  head_priority_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic left_lt;    // left neighbour ranks below the new entry
    logic cur_lt;     // this slot ranks below the new entry
    logic at_count;   // first free slot
    logic in_range;   // slot lies at or below the fill level
    logic take_left;
    logic take_new;

    if (k == 0) begin : g_head
      assign left_lt = 1'b0;
    end else begin : g_body
      assign left_lt = (pri_q[k-1] < item_priority_i);
    end

    assign cur_lt    = (pri_q[k] < item_priority_i);
    assign at_count  = (count_i == CntW'(k));
    assign in_range  = (CntW'(k) <= count_i);
    assign take_left = (k != 0) && in_range && left_lt;
    assign take_new  = in_range && !left_lt && (at_count || cur_lt);

    if (k == DEPTH - 1) begin : g_tail
      always_comb begin
        val_d[k] = val_q[k];
        pri_d[k] = pri_q[k];
        if (cmd_i.do_push) begin
          if (take_left) begin
            val_d[k] = val_q[k-1];
            pri_d[k] = pri_q[k-1];
          end else if (take_new) begin
            val_d[k] = item_value_i;
            pri_d[k] = item_priority_i;
          end
        end
      end
    end else begin : g_inner
      always_comb begin
        val_d[k] = val_q[k];
        pri_d[k] = pri_q[k];
        if (cmd_i.do_pop) begin
          val_d[k] = val_q[k+1];
          pri_d[k] = pri_q[k+1];
        end else if (cmd_i.do_push) begin
          if (take_left) begin
            val_d[k] = val_q[(k == 0) ? 0 : k-1];
            pri_d[k] = pri_q[(k == 0) ? 0 : k-1];
          end else if (take_new) begin
            val_d[k] = item_value_i;
            pri_d[k] = item_priority_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push || cmd_i.do_pop) begin
      val_q <= val_d;
      pri_q <= pri_d;
    end
    if (cmd_i.load_out) begin
      head_value_q    <= cmd_i.do_pop ? val_q[0] : '0;
      head_priority_q <= cmd_i.do_pop ? pri_q[0] : '0;
    end
  end

  assign head_value_o    = head_value_q;
  assign head_priority_o = head_priority_q;

endmodule

[hdl/sorted_priority_queue_unit.sv]
// Channel  Direction  Payload  Handshake
// in       input      in_t     in_valid_i / in_ready_o
// out      output     out_t    out_valid_o / out_ready_i
//
// Each push or pop completes in the cycle it is accepted: every slot of the
// cell array compares its priority with the new entry and shifts or loads
// in parallel, so one transaction per cycle is sustained while the output is not stalled.
// The result is held in an output register; a new transaction is taken
// while that result is being read in the same cycle.
// Reset empties the queue; slot contents are not cleared.
// A stalled output blocks further input until the result is taken.
//
// Top level of the sorted priority queue; uses spq_pkg, spq_ctrl,
// spq_datapath.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  spq_cmd_t          cmd;
  logic [CntW-1:0]   count;
  status_e           status;
  logic [ValueW-1:0] head_value;
  logic [PrioW-1:0]  head_priority;

  spq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (in_data_i.func),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status),
    .cmd_o      (cmd),
    .count_o    (count)
  );

  spq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .count_i        (count),
    .item_value_i   (in_data_i.item_value),
    .item_priority_i(in_data_i.item_priority),
    .head_value_o   (head_value),
    .head_priority_o(head_priority)
  );

  // Count only moves on accepted transactions, so it is the post-operation
  // occupancy for as long as the result is shown.
  always_comb begin
    out_data_o.status        = status;
    out_data_o.head_value    = head_value;
    out_data_o.head_priority = head_priority;
    out_data_o.occupancy     = OccW'(count);
  end

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.func == FuncPush) && (count != CntW'(DEPTH))
    |=> count == $past(count) + CntW'(1))
    else $error("accepted push did not add an entry");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.func == FuncPop) && (count != '0)
    |=> count == $past(count) - CntW'(1))
    else $error("accepted pop did not remove an entry");

  a_underflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk)
    |-> (out_data_o.head_value == '0) && (out_data_o.head_priority == '0))
    else $error("refused transaction reports a non-zero head");

endmodule

[test/sorted_priority_queue_unit_test.sv]
// Self-checking testbench for sorted_priority_queue_unit: directed rows, then
// random push/pop phases checked against an in-bench model of the sorted queue.
// Depends on spq_pkg and the RTL of the unit.
module sorted_priority_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned Depth         = DefaultDepth;
  localparam int          RandomOps     = 1350;
  localparam int          HoldOffCycles = 300;
  localparam int          CycleLimit    = 600000;
  localparam int          MaxReported   = 10;

  typedef struct {
    in_t  op;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  sorted_priority_queue_unit #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Model of the sorted queue contents
  logic [ValueW-1:0] model_val [Depth];
  logic [PrioW-1:0]  model_prio[Depth];
  int                model_count;

  out_t      pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatches;
  int        ops_sent;
  int        cycle_count;
  bit        hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic out_t predict_queue_op(in_t op);
    out_t res;
    int   slot;
    res = '0;
    res.status = StOk;
    if (op.func == FuncPush) begin
      if (model_count >= Depth) begin
        res.status = StOverflow;
      end else begin
        // Walk the new entry forward past every strictly lower priority
        slot = model_count;
        while (slot > 0 && model_prio[slot-1] < op.item_priority) begin
          model_val[slot]  = model_val[slot-1];
          model_prio[slot] = model_prio[slot-1];
          slot--;
        end
        model_val[slot]  = op.item_value;
        model_prio[slot] = op.item_priority;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status = StUnderflow;
      end else begin
        res.head_value    = model_val[0];
        res.head_priority = model_prio[0];
        for (int k = 1; k < model_count; k++) begin
          model_val[k-1]  = model_val[k];
          model_prio[k-1] = model_prio[k];
        end
        model_count--;
      end
    end
    res.occupancy = model_count[OccW-1:0];
    return res;
  endfunction

  function automatic void add_row(logic fn, logic [ValueW-1:0] v, logic [PrioW-1:0] p,
                                  bit typed, status_e st, logic [ValueW-1:0] hv,
                                  logic [PrioW-1:0] hp, int occ);
    stim_row_t row;
    row.op.func               = fn;
    row.op.item_value         = v;
    row.op.item_priority      = p;
    row.typed                 = typed;
    row.want.status           = st;
    row.want.head_value       = hv;
    row.want.head_priority    = hp;
    row.want.occupancy        = occ[OccW-1:0];
    directed_rows.push_back(row);
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PrioW-1:0] pick_priority(int mode);
    case (mode)
      0: return PrioW'($urandom_range(0, 255));
      1: begin
        // Extremes and the middle, so ties are frequent
        case ($urandom_range(0, 4))
          0: return 8'h00;
          1: return 8'h01;
          2: return 8'h80;
          3: return 8'hFE;
          default: return 8'hFF;
        endcase
      end
      default: return PrioW'($urandom_range(100, 103));
    endcase
  endfunction

  task automatic send_op(input in_t op, input bit typed, input out_t want, input int gap);
    out_t guess;
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (!in_ready_o);
    guess = predict_queue_op(op);
    pending_results.push_back(typed ? want : guess);
    ops_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic note_mismatch(input bit unexpected, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      if (unexpected)
        $display("%0t: unexpected result st=%0d val=%h pri=%h occ=%0d", $realtime,
                 got.status, got.head_value, got.head_priority, got.occupancy);
      else
        $display({"%0t: result mismatch: exp st=%0d val=%h pri=%h occ=%0d, ",
                  "act st=%0d val=%h pri=%h occ=%0d"},
                 $realtime, want.status, want.head_value, want.head_priority, want.occupancy,
                 got.status, got.head_value, got.head_priority, got.occupancy);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (pending_results.size() == 0) begin
        note_mismatch(1'b1, '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.head_value !== want.head_value ||
            got.head_priority !== want.head_priority || got.occupancy !== want.occupancy)
          note_mismatch(1'b0, want, got);
      end
    end
  end

  // Receiver: random stalls, ready stretches, and one long hold-off on request
  initial begin
    int stall_left;
    int run_left;
    stall_left  = 0;
    run_left    = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready_i <= 1'b1;
        run_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
        if ($urandom_range(0, 9) == 0) run_left = $urandom_range(20, 120);
        else run_left = $urandom_range(0, 3);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_t op;
    int  phase;
    int  phase_len;
    int  push_pct;
    int  prio_mode;
    bit  no_gaps;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    model_count  = 0;
    mismatches   = 0;
    ops_sent     = 0;
    cycle_count  = 0;
    hold_off_req = 1'b0;

    // Pop from empty ignores its value and priority fields
    add_row(FuncPop,  16'hFFFF, 8'hFF, 1, StUnderflow, '0, '0, 0);
    add_row(FuncPush, 16'h0000, 8'h00, 1, StOk, '0, '0, 1);
    add_row(FuncPush, 16'hFFFF, 8'hFF, 1, StOk, '0, '0, 2);
    add_row(FuncPush, 16'h1234, 8'h80, 0, StOk, '0, '0, 0);
    add_row(FuncPush, 16'h5678, 8'h80, 0, StOk, '0, '0, 0);
    add_row(FuncPush, 16'h9ABC, 8'h80, 0, StOk, '0, '0, 0);
    // Ties at the head and at the tail keep arrival order
    add_row(FuncPush, 16'h0001, 8'hFF, 0, StOk, '0, '0, 0);
    add_row(FuncPush, 16'h2222, 8'h00, 0, StOk, '0, '0, 0);
    add_row(FuncPop,  16'h0000, 8'h00, 1, StOk, 16'hFFFF, 8'hFF, 6);
    add_row(FuncPop,  16'hA5A5, 8'h5A, 1, StOk, 16'h0001, 8'hFF, 5);
    add_row(FuncPush, 16'hAAAA, 8'h7F, 0, StOk, '0, '0, 0);
    repeat (6) add_row(FuncPop, 16'h5555, 8'hAA, 0, StOk, '0, '0, 0);
    add_row(FuncPop,  16'h0000, 8'h00, 1, StUnderflow, '0, '0, 0);
    add_row(FuncPush, 16'h8000, 8'h01, 0, StOk, '0, '0, 0);
    add_row(FuncPush, 16'h7FFF, 8'hFE, 0, StOk, '0, '0, 0);
    add_row(FuncPop,  16'h0000, 8'h00, 0, StOk, '0, '0, 0);
    add_row(FuncPop,  16'h0000, 8'h00, 0, StOk, '0, '0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want, pick_gap());
    drain_results();

    // Fill past full first, then empty past zero, then mixed phases
    phase = 0;
    while (ops_sent < RandomOps) begin
      phase_len = $urandom_range(40, 150);
      prio_mode = $urandom_range(0, 2);
      no_gaps   = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin push_pct = 100; phase_len = 72; end
        1: begin push_pct = 0;   phase_len = 72; end
        default: begin
          case ($urandom_range(0, 4))
            0: push_pct = 85;
            1: push_pct = 50;
            2: push_pct = 15;
            3: push_pct = 95;
            default: push_pct = 60;
          endcase
        end
      endcase
      if (phase_len > RandomOps - ops_sent) phase_len = RandomOps - ops_sent;
      if (phase == 3) begin
        // Keep offering while the receiver holds off, so the input stalls
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
      end
      repeat (phase_len) begin
        op.func          = ($urandom_range(0, 99) < push_pct) ? FuncPush : FuncPop;
        op.item_value    = ValueW'($urandom_range(0, 65535));
        op.item_priority = pick_priority(prio_mode);
        send_op(op, 1'b0, '0, no_gaps ? 0 : pick_gap());
      end
      if (phase % 3 == 2) drain_results();
      phase++;
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
